// ----- sv/ctfr_pkg.sv -----
// ----------------------------------------------------------------------------
// ctfr_pkg
// Shared types, constants and the CRC-8 byte update for the TLV frame
// receiver.
// ----------------------------------------------------------------------------
package ctfr_pkg;

   // Largest payload a frame may declare, used as the default size.
   localparam int DEF_MAX_PAYLOAD = 256;

   // Width of the register index on the configuration port.
   localparam int CSR_INDEX_W = 8;

   // CRC-8 generator polynomial (x^8 + x^2 + x + 1), no reflection, no final xor.
   localparam logic [7:0] CRC_POLY = 8'h07;

   // Delimiter values after reset.
   localparam logic [7:0] START_DELIM_RESET = 8'hAA;
   localparam logic [7:0] END_DELIM_RESET   = 8'h55;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_START_DELIM = 8'd0,
      CSR_END_DELIM   = 8'd1
   } csr_index_type;

   // Event codes carried on each result.
   typedef enum logic [2:0] {
      EV_NONE   = 3'd0,
      EV_HEADER = 3'd1,
      EV_DATA   = 3'd2,
      EV_GOOD   = 3'd3,
      EV_CRCERR = 3'd4,
      EV_NOEND  = 3'd5,
      EV_BADLEN = 3'd6
   } event_type;

   // One result item.
   typedef struct packed {
      event_type   event_res;
      logic [7:0]  frame_type;
      logic [15:0] frame_length;
      logic [7:0]  data_byte;
      logic [7:0]  byte_index;
   } result_type;

   // Advance the CRC by one byte, MSB first.
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] v;
      v = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         if (v[7]) begin
            v = {v[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            v = {v[6:0], 1'b0};
         end
      end
      return v;
   endfunction

endpackage

// ----- sv/crc8_tlv_frame_receiver.sv -----
// A transferred byte is held in the input register, stepped through the parser and
// written into the result buffer, whose head drives the result ports.
// One byte per cycle unless stalled; CRC update and phase logic are combinational.
// The input register stalls only when it holds a byte and both result slots are full.
// Synchronous active-high reset clears the frame state and both result slots,
// and sets the delimiters to 0xAA (start) and 0x55 (end).
// ----------------------------------------------------------------------------
// crc8_tlv_frame_receiver
// Receives one byte per transfer, recognizes start/type/length/payload/CRC/end
// frames with an incremental CRC-8, and reports one event per byte.
// ----------------------------------------------------------------------------
module crc8_tlv_frame_receiver
   import ctfr_pkg::*;
#(
   parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
   input  logic                   clock,
   input  logic                   reset,
   // Byte input channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_rx_byte,
   // Result channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [2:0]             rsp_event_res,
   output logic [7:0]             rsp_frame_type,
   output logic [15:0]            rsp_frame_length,
   output logic [7:0]             rsp_data_byte,
   output logic [7:0]             rsp_byte_index,
   // Configuration write channel
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_data
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic [7:0] start_delim_ff;
   logic [7:0] end_delim_ff;
   logic       req_xfer;
   logic       advance;
   logic       skid_full;
   result_type step_result;
   result_type head;

   // Configuration registers; writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_delim_ff <= START_DELIM_RESET;
         end_delim_ff   <= END_DELIM_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_START_DELIM) begin
            start_delim_ff <= csr_data;
         end
         if (csr_index == CSR_END_DELIM) begin
            end_delim_ff <= csr_data;
         end
      end
   end

   // Input register: refills in the same cycle its byte moves on.
   assign req_stall   = in_valid_ff && skid_full;
   assign req_xfer    = req_valid && !req_stall;
   assign advance     = in_valid_ff && !skid_full;
   assign in_valid_in = req_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   // Frame recognizer.
   ctfr_parser #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .rx_byte     (in_byte_ff),
      .start_delim (start_delim_ff),
      .end_delim   (end_delim_ff),
      .result      (step_result)
   );

   // Result buffer.
   ctfr_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (advance),
      .push_data (step_result),
      .pop_stall (rsp_stall),
      .out_valid (rsp_valid),
      .out_data  (head),
      .full      (skid_full)
   );

   assign rsp_event_res    = head.event_res;
   assign rsp_frame_type   = head.frame_type;
   assign rsp_frame_length = head.frame_length;
   assign rsp_data_byte    = head.data_byte;
   assign rsp_byte_index   = head.byte_index;

endmodule

// ----- sv/ctfr_parser.sv -----
// ----------------------------------------------------------------------------
// ctfr_parser
// Frame recognizer: phase state machine, held header fields, payload counter
// and running CRC. Produces one result for every byte stepped through it.
// ----------------------------------------------------------------------------
module ctfr_parser
   import ctfr_pkg::*;
#(
   parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] rx_byte,
   input  logic [7:0] start_delim,
   input  logic [7:0] end_delim,
   output result_type result
);

   localparam int COUNT_W = $clog2(MAX_PAYLOAD + 1);

   typedef enum logic [6:0] {
      PH_WAIT = 7'b0000001,
      PH_TYPE = 7'b0000010,
      PH_LLO  = 7'b0000100,
      PH_LHI  = 7'b0001000,
      PH_DATA = 7'b0010000,
      PH_CRC  = 7'b0100000,
      PH_END  = 7'b1000000
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [7:0]         type_ff, type_in;
   logic [15:0]        len_ff, len_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [7:0]         crc_ff, crc_in;
   logic [7:0]         rcrc_ff, rcrc_in;

   logic [7:0]         crc_upd;
   logic [COUNT_W-1:0] count_inc;
   logic [15:0]        len_full;
   event_type          ev;
   logic [7:0]         dbyte;
   logic [7:0]         didx;

   assign crc_upd   = crc8_update(crc_ff, rx_byte);
   assign count_inc = count_ff + COUNT_W'(1);
   assign len_full  = {rx_byte, len_ff[7:0]};

   // Next state and result for the byte at hand.
   always_comb begin
      phase_in = phase_ff;
      type_in  = type_ff;
      len_in   = len_ff;
      count_in = count_ff;
      crc_in   = crc_ff;
      rcrc_in  = rcrc_ff;
      ev       = EV_NONE;
      dbyte    = '0;
      didx     = '0;
      unique case (phase_ff)
         PH_TYPE: begin
            type_in  = rx_byte;
            crc_in   = crc_upd;
            phase_in = PH_LLO;
         end
         PH_LLO: begin
            len_in   = {8'h00, rx_byte};
            crc_in   = crc_upd;
            phase_in = PH_LHI;
         end
         PH_LHI: begin
            len_in   = len_full;
            crc_in   = crc_upd;
            count_in = '0;
            if (len_full > 16'(MAX_PAYLOAD)) begin
               ev       = EV_BADLEN;
               phase_in = PH_WAIT;
            end else begin
               ev       = EV_HEADER;
               phase_in = (len_full == 16'h0000) ? PH_CRC : PH_DATA;
            end
         end
         PH_DATA: begin
            ev       = EV_DATA;
            dbyte    = rx_byte;
            didx     = 8'(count_ff);
            crc_in   = crc_upd;
            count_in = count_inc;
            if (16'(count_inc) >= len_ff) begin
               phase_in = PH_CRC;
            end
         end
         PH_CRC: begin
            rcrc_in  = rx_byte;
            phase_in = PH_END;
         end
         PH_END: begin
            if (rx_byte != end_delim) begin
               ev = EV_NOEND;
            end else if (crc_ff == rcrc_ff) begin
               ev = EV_GOOD;
            end else begin
               ev = EV_CRCERR;
            end
            phase_in = PH_WAIT;
         end
         default: begin
            // Waiting for a start delimiter; other bytes are dropped.
            phase_in = PH_WAIT;
            if (rx_byte == start_delim) begin
               crc_in   = '0;
               phase_in = PH_TYPE;
            end
         end
      endcase
   end

   // Result shows the held fields after this byte.
   always_comb begin
      result.event_res    = ev;
      result.frame_type   = type_in;
      result.frame_length = len_in;
      result.data_byte    = dbyte;
      result.byte_index   = didx;
   end

   // State registers advance once per byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
         type_ff  <= '0;
         len_ff   <= '0;
         count_ff <= '0;
         crc_ff   <= '0;
         rcrc_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         type_ff  <= type_in;
         len_ff   <= len_in;
         count_ff <= count_in;
         crc_ff   <= crc_in;
         rcrc_ff  <= rcrc_in;
      end
   end

endmodule

// ----- sv/ctfr_skid.sv -----
// ----------------------------------------------------------------------------
// ctfr_skid
// Two-entry result buffer. Holds finished results while the consumer stalls,
// so the parser can keep going without a combinational path from the stall.
// ----------------------------------------------------------------------------
module ctfr_skid
   import ctfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   input  logic       pop_stall,
   output logic       out_valid,
   output result_type out_data,
   output logic       full
);

   result_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign out_valid = (count_ff != 2'd0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign full      = (count_ff == 2'd2);
   assign pop       = out_valid && !pop_stall;

   // Pointer and occupancy bookkeeping.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Result storage; no reset needed.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- sv/ctfr_checker.sv -----
// ----------------------------------------------------------------------------
// ctfr_checker
// Port-level checks on the TLV frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module ctfr_checker
   import ctfr_pkg::*;
#(
   parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [2:0]             rsp_event_res,
   input logic [7:0]             rsp_frame_type,
   input logic [15:0]            rsp_frame_length,
   input logic [7:0]             rsp_data_byte,
   input logic [7:0]             rsp_byte_index
);

   // A stalled result stays valid and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_res)
         && $stable(rsp_frame_type) && $stable(rsp_frame_length)
         && $stable(rsp_data_byte) && $stable(rsp_byte_index))
      else $error("stalled result changed");

   // No result is offered right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A payload byte always lies inside the declared length.
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_res == EV_DATA) |-> ({8'h00, rsp_byte_index} < rsp_frame_length))
      else $error("payload index beyond frame length");

   // Header accepted and bad length agree with the size limit.
   a_length_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_event_res == EV_HEADER && rsp_frame_length > 16'(MAX_PAYLOAD))
         || (rsp_event_res == EV_BADLEN && rsp_frame_length <= 16'(MAX_PAYLOAD)))
      |-> 1'b0)
      else $error("length verdict disagrees with limit");

   // Data fields are zero unless the event is a payload byte.
   a_data_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_res != EV_DATA) |-> (rsp_data_byte == 8'h00)
         && (rsp_byte_index == 8'h00))
      else $error("data fields set outside payload event");

endmodule

bind crc8_tlv_frame_receiver ctfr_checker #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_checker (.*);
